FILE: hdl/tscm_pkg.sv
// shared types, constants and helpers for the transport stream continuity monitor
package tscm_pkg;

	localparam int PID_W       = 13;
	localparam int PID_SPACE   = 8192;
	localparam int COUNT_WIDTH = 32;
	localparam int OUT_W       = 32;
	localparam int ADDR_W      = (PID_SPACE > 1) ? $clog2(PID_SPACE) : 1;

	localparam logic [PID_W-1:0] NULL_PID    = 13'h1fff;
	localparam logic [4:0]       UNSEEN_MARK = 5'h1f;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [ADDR_W-1:0]      addr_t;

	// one per-pid record: last counter (bit 4 set means unseen) and three counters
	typedef struct packed {
		logic [4:0] last_cc;
		count_t     pkts;
		count_t     scr;
		count_t     errs;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{last_cc: UNSEEN_MARK, pkts: '0, scr: '0, errs: '0};

	typedef struct packed {
		logic [PID_W-1:0] packet_pid;
		logic             first_seen;
		logic             cc_error;
		logic [3:0]       expected_cc;
		logic [3:0]       received_cc;
		logic             is_scrambled;
		logic [OUT_W-1:0] pid_packets;
		logic [OUT_W-1:0] pid_scrambled;
		logic [OUT_W-1:0] pid_errors;
		logic [OUT_W-1:0] total_packets;
	} result_t;

	function automatic count_t sat_inc(input count_t v);
		count_t r;
		r = (&v) ? v : v + count_t'(1);
		return r;
	endfunction

endpackage

FILE: hdl/ts_continuity_monitor.sv
// transport stream continuity counter monitor, per-pid state in one record memory
// path: an accepted header is held in the stage 1 registers, then its result is registered in out_q behind out_valid
// throughput: one header per cycle while in_stall is low, set by the single read-modify-write of the record memory
// back-to-back headers on the same pid are served by a one-deep bypass of the written record
// reset: arst_n clears control at once, then a sweep writes the reset record to all
// PID_SPACE (8192) entries, one per cycle, with in_stall held high until the sweep ends
module ts_continuity_monitor
	import tscm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             pid_high_byte,
	input  logic [7:0]             pid_low_byte,
	input  logic [7:0]             control_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [PID_W-1:0]       packet_pid,
	output logic                   first_seen,
	output logic                   cc_error,
	output logic [3:0]             expected_cc,
	output logic [3:0]             received_cc,
	output logic                   is_scrambled,
	output logic [OUT_W-1:0]       pid_packets,
	output logic [OUT_W-1:0]       pid_scrambled,
	output logic [OUT_W-1:0]       pid_errors,
	output logic [OUT_W-1:0]       total_packets
);

	// per-pid record memory, one write port and one registered read port
	entry_t mem [PID_SPACE];

	// clearing sweep after reset
	logic   clearing_q;
	addr_t  clr_idx_q;

	// stage 1: header fields and the record read for it
	logic             v_s1;
	logic [PID_W-1:0] pid_s1;
	logic [7:0]       ctl_s1;
	entry_t           rd_s1;
	logic             fwd_s1;
	entry_t           fwd_ent_s1;

	// output register and running total
	logic    out_v_q;
	result_t out_q;
	count_t  total_q;

	logic             in_acc;
	logic             adv;
	logic [PID_W-1:0] in_pid;
	logic             in_space;
	entry_t           cur;
	entry_t           upd;
	logic             first;
	logic [3:0]       expect_cc;
	logic             err;
	logic             scr;
	logic             s1_wr;
	logic             mem_we;
	addr_t            mem_wa;
	entry_t           mem_wd;
	count_t           total_nxt;
	result_t          res;

	// stage 1 moves on when the output register is empty or being drained
	assign adv      = !out_v_q || !out_stall;
	assign in_stall = clearing_q || (v_s1 && !adv);
	assign in_acc   = in_valid && !in_stall;
	assign in_pid   = {pid_high_byte[4:0], pid_low_byte};

	// read-modify-write of the record in stage 1
	always_comb begin
		cur       = fwd_s1 ? fwd_ent_s1 : rd_s1;
		in_space  = ({1'b0, pid_s1} < (PID_W+1)'(PID_SPACE));
		scr       = |ctl_s1[7:6];
		first     = cur.last_cc[4];
		expect_cc = first ? 4'd0 : (cur.last_cc[3:0] + {3'd0, ctl_s1[4]});
		// null pid is tracked but never flagged
		err       = !first && (pid_s1 != NULL_PID) && (expect_cc != ctl_s1[3:0]);

		upd         = cur;
		upd.last_cc = {1'b0, ctl_s1[3:0]};
		upd.pkts    = sat_inc(cur.pkts);
		if (scr) begin
			upd.scr = sat_inc(cur.scr);
		end
		if (err) begin
			upd.errs = sat_inc(cur.errs);
		end

		total_nxt = sat_inc(total_q);

		res               = '0;
		res.packet_pid    = pid_s1;
		res.received_cc   = ctl_s1[3:0];
		res.is_scrambled  = scr;
		res.total_packets = OUT_W'(total_nxt);
		// a pid beyond the tracked space only bumps the total
		if (in_space) begin
			res.first_seen    = first;
			res.cc_error      = err;
			res.expected_cc   = expect_cc;
			res.pid_packets   = OUT_W'(upd.pkts);
			res.pid_scrambled = OUT_W'(upd.scr);
			res.pid_errors    = OUT_W'(upd.errs);
		end

		s1_wr  = v_s1 && adv && in_space;
		mem_we = clearing_q || s1_wr;
		mem_wa = clearing_q ? clr_idx_q : pid_s1[ADDR_W-1:0];
		mem_wd = clearing_q ? ENTRY_RESET : upd;
	end

	// record memory: read before write on the same edge
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (in_acc) begin
			rd_s1 <= mem[in_pid[ADDR_W-1:0]];
		end
	end

	// stage 1 payload and bypass record
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pid_s1     <= in_pid;
			ctl_s1     <= control_byte;
			fwd_ent_s1 <= upd;
		end
		if (v_s1 && adv) begin
			out_q <= res;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
			v_s1       <= 1'b0;
			fwd_s1     <= 1'b0;
			out_v_q    <= 1'b0;
			total_q    <= '0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + addr_t'(1);
				if (clr_idx_q == addr_t'(PID_SPACE - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (in_acc) begin
				v_s1 <= 1'b1;
				// the record being written this edge is not yet visible to the read
				fwd_s1 <= s1_wr && (pid_s1[ADDR_W-1:0] == in_pid[ADDR_W-1:0]);
			end else if (adv) begin
				v_s1   <= 1'b0;
				fwd_s1 <= 1'b0;
			end
			if (v_s1 && adv) begin
				out_v_q <= 1'b1;
				total_q <= total_nxt;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_v_q;
	assign packet_pid    = out_q.packet_pid;
	assign first_seen    = out_q.first_seen;
	assign cc_error      = out_q.cc_error;
	assign expected_cc   = out_q.expected_cc;
	assign received_cc   = out_q.received_cc;
	assign is_scrambled  = out_q.is_scrambled;
	assign pid_packets   = out_q.pid_packets;
	assign pid_scrambled = out_q.pid_scrambled;
	assign pid_errors    = out_q.pid_errors;
	assign total_packets = out_q.total_packets;

	// no header taken while the sweep runs
	a_no_acc_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !in_acc && !v_s1)
		else $error("header accepted during clearing sweep");

	// bypass only alongside a live stage 1 beat
	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v_s1)
		else $error("bypass set without stage 1 beat");

	// a first-seen pid is never an error and expects zero
	a_first_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && first_seen) |-> (!cc_error && expected_cc == 4'd0))
		else $error("first-seen beat flagged or nonzero expectation");

	// the total, advanced by one per delivered result until saturation, is carried to the output
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv) |=> (out_q.total_packets == $past(res.total_packets)))
		else $error("total count not carried to output");

endmodule
